FILE: rtl/prologue_save_slot_scanner_top_macros.svh
// assertion macros for the prologue save-slot scanner checker
`ifndef PROLOGUE_SAVE_SLOT_SCANNER_TOP_MACROS_SVH
`define PROLOGUE_SAVE_SLOT_SCANNER_TOP_MACROS_SVH

// implication in the same cycle
`define PSSS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psss check failed");

// implication on the following cycle
`define PSSS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psss check failed");

`endif

FILE: rtl/psss_pkg.sv
// shared types and constants of the prologue save-slot scanner
package psss_pkg;

   localparam int MAX_SCAN  = 15;
   localparam int NSLOTS    = 17;
   localparam int RET_SLOT  = 16;
   localparam int FRAME_REG = 14;
   localparam int CNT_W     = $clog2(MAX_SCAN + 1);
   localparam int SLOT_W    = $clog2(NSLOTS);
   localparam int IDX_W     = $clog2(NSLOTS + 1);

   // instruction patterns
   localparam logic [15:0] PUSH_MASK  = 16'hff0f;
   localparam logic [15:0] PUSH_MATCH = 16'h2f06;
   localparam logic [15:0] STRET_WORD = 16'h4f22;
   localparam logic [15:0] HI_MASK    = 16'hff00;
   localparam logic [15:0] LDR3_MATCH = 16'h1a00;
   localparam logic [15:0] SHL_WORD   = 16'h4300;
   localparam logic [15:0] ADDR3_WORD = 16'h3f3c;
   localparam logic [15:0] ADDI_MATCH = 16'h7f00;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH,
      OP_STRET,
      OP_LDR3,
      OP_SHL,
      OP_ADDR3,
      OP_ADDI
   } op_type;

   // controller to datapath
   typedef struct packed {
      logic step;
      logic prep;
      logic adv_idx;
      logic load_reg;
      logic load_sum;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_end;
      logic idx_end;
      logic idx_valid;
   } stat_type;

   function automatic op_type decode_op(input logic [15:0] w);
      op_type op;
      op = OP_NONE;
      priority if ((w & PUSH_MASK) == PUSH_MATCH) op = OP_PUSH;
      else if (w == STRET_WORD)                  op = OP_STRET;
      else if ((w & HI_MASK) == LDR3_MATCH)      op = OP_LDR3;
      else if (w == SHL_WORD)                    op = OP_SHL;
      else if (w == ADDR3_WORD)                  op = OP_ADDR3;
      else if ((w & HI_MASK) == ADDI_MATCH)      op = OP_ADDI;
      else                                       op = OP_NONE;
      return op;
   endfunction

endpackage

FILE: rtl/psss_ctrl.sv
// controller: sequences scanning, setup and result emission
module psss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  psss_pkg::stat_type stat,
   output psss_pkg::cmd_type  cmd
);
   import psss_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               if (stat.scan_end) state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.idx_end) begin
               if (out_free) begin
                  cmd.load_sum = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (stat.idx_valid) begin
               if (out_free) begin
                  cmd.load_reg = 1'b1;
                  cmd.adv_idx  = 1'b1;
               end
            end else begin
               cmd.adv_idx = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output valid flag
   always_comb begin
      if (cmd.load_reg || cmd.load_sum) rsp_valid_in = 1'b1;
      else if (rsp_ready)               rsp_valid_in = 1'b0;
      else                              rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/psss_dp.sv
// datapath: decode, slot store, address arithmetic and result register
module psss_dp (
   input  logic               clock,
   input  logic               reset,
   input  psss_pkg::cmd_type  cmd,
   output psss_pkg::stat_type stat,
   input  logic [15:0]        req_insn_word,
   input  logic               req_start_req,
   input  logic [31:0]        req_frame_base,
   output logic [4:0]         rsp_reg_id,
   output logic [31:0]        rsp_save_address,
   output logic               rsp_is_summary,
   output logic               rsp_leaf,
   output logic               rsp_has_frame_reg,
   output logic signed [31:0] rsp_frame_offset,
   output logic [31:0]        rsp_caller_stack,
   output logic               rsp_last
);
   import psss_pkg::*;

   // scan state
   logic [NSLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [31:0]       slot_depth_mem [NSLOTS];
   logic [31:0]       depth_ff, depth_in;
   logic [31:0]       r3_ff, r3_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              leaf_ff, leaf_in;
   logic              scanning_ff;
   logic [31:0]       base_ff;

   // emission state
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [31:0]       adj_ff;
   logic [31:0]       dm4_ff;
   logic [31:0]       rd_depth_ff;
   logic [31:0]       fp_depth_ff;

   // result register
   logic [4:0]         reg_id_ff;
   logic [31:0]        save_addr_ff;
   logic               is_sum_ff, leaf_out_ff, has_fp_ff, last_ff;
   logic signed [31:0] frame_off_ff;
   logic [31:0]        caller_ff;

   logic              active, commit;
   op_type            op;
   logic [31:0]       imm;
   logic [SLOT_W-1:0] wr_slot;
   logic              wr_en;
   logic [31:0]       wr_depth;
   logic [SLOT_W-1:0] rd_idx;
   logic [CNT_W-1:0]  cnt_inc;
   logic [31:0]       fp_slot;
   logic              has_fp;

   assign active  = req_start_req || scanning_ff;
   assign commit  = cmd.step && active;
   assign op      = decode_op(req_insn_word);
   assign imm     = {{24{req_insn_word[7]}}, req_insn_word[7:0]};
   assign wr_slot = (op == OP_STRET) ? SLOT_W'(RET_SLOT) : SLOT_W'(req_insn_word[7:4]);
   assign wr_en   = commit && ((op == OP_PUSH) || (op == OP_STRET));
   assign wr_depth = req_start_req ? 32'd0 : depth_ff;

   // decode step on top of a cleared state for a start request
   always_comb begin
      logic [NSLOTS-1:0] valid_base;
      logic [31:0]       depth_base;
      logic [31:0]       r3_base;
      logic [CNT_W-1:0]  cnt_base;
      logic              leaf_base;
      valid_base = req_start_req ? '0 : slot_valid_ff;
      depth_base = req_start_req ? 32'd0 : depth_ff;
      r3_base    = req_start_req ? 32'd0 : r3_ff;
      cnt_base   = req_start_req ? '0 : cnt_ff;
      leaf_base  = req_start_req ? 1'b1 : leaf_ff;
      slot_valid_in = valid_base;
      depth_in      = depth_base;
      r3_in         = r3_base;
      leaf_in       = leaf_base;
      cnt_inc       = cnt_base + CNT_W'(1);
      cnt_in        = cnt_inc;
      unique case (op)
         OP_PUSH, OP_STRET: begin
            slot_valid_in[wr_slot] = 1'b1;
            depth_in = depth_base + 32'd4;
            if (op == OP_STRET) leaf_in = 1'b0;
         end
         OP_LDR3:  r3_in    = imm;
         OP_SHL:   r3_in    = {r3_base[30:0], 1'b0};
         OP_ADDR3: depth_in = depth_base - r3_base;
         OP_ADDI:  depth_in = depth_base - imm;
         OP_NONE:  cnt_in   = cnt_base;
         default:  cnt_in   = cnt_base;
      endcase
   end

   assign stat.scan_end  = active && ((op == OP_NONE) || (cnt_inc >= CNT_W'(MAX_SCAN)));
   assign stat.idx_end   = (idx_ff == IDX_W'(NSLOTS));
   assign stat.idx_valid = (idx_ff < IDX_W'(NSLOTS)) && slot_valid_ff[idx_ff[SLOT_W-1:0]];

   assign has_fp   = slot_valid_ff[FRAME_REG];
   assign fp_slot  = has_fp ? fp_depth_ff : 32'hffff_ffff;

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         depth_ff      <= '0;
         r3_ff         <= '0;
         cnt_ff        <= '0;
         leaf_ff       <= 1'b1;
         scanning_ff   <= 1'b0;
         base_ff       <= '0;
      end else if (commit) begin
         slot_valid_ff <= slot_valid_in;
         depth_ff      <= depth_in;
         r3_ff         <= r3_in;
         cnt_ff        <= cnt_in;
         leaf_ff       <= leaf_in;
         scanning_ff   <= !stat.scan_end;
         if (req_start_req) base_ff <= req_frame_base;
      end
   end

   // next walk index
   always_comb begin
      if (cmd.prep)         idx_in = '0;
      else if (cmd.adv_idx) idx_in = idx_ff + IDX_W'(1);
      else                  idx_in = idx_ff;
   end

   assign rd_idx = (idx_in < IDX_W'(NSLOTS)) ? idx_in[SLOT_W-1:0] : SLOT_W'(0);

   // slot depth store, no reset; read data follows the walk index
   always_ff @(posedge clock) begin
      if (wr_en) slot_depth_mem[wr_slot] <= wr_depth;
      rd_depth_ff <= slot_depth_mem[rd_idx];
      if (cmd.prep) fp_depth_ff <= slot_depth_mem[FRAME_REG];
   end

   // slot walk index and address offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         adj_ff <= base_ff + depth_ff - 32'd4;
         dm4_ff <= depth_ff - 32'd4;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_reg) begin
         reg_id_ff    <= 5'(idx_ff);
         save_addr_ff <= adj_ff - rd_depth_ff;
         is_sum_ff    <= 1'b0;
         leaf_out_ff  <= 1'b0;
         has_fp_ff    <= 1'b0;
         frame_off_ff <= '0;
         caller_ff    <= '0;
         last_ff      <= 1'b0;
      end else if (cmd.load_sum) begin
         reg_id_ff    <= '0;
         save_addr_ff <= '0;
         is_sum_ff    <= 1'b1;
         leaf_out_ff  <= leaf_ff;
         has_fp_ff    <= has_fp;
         frame_off_ff <= signed'(dm4_ff - fp_slot);
         caller_ff    <= has_fp ? 32'd0 : base_ff - 32'd4;
         last_ff      <= 1'b1;
      end
   end

   assign rsp_reg_id        = reg_id_ff;
   assign rsp_save_address  = save_addr_ff;
   assign rsp_is_summary    = is_sum_ff;
   assign rsp_leaf          = leaf_out_ff;
   assign rsp_has_frame_reg = has_fp_ff;
   assign rsp_frame_offset  = frame_off_ff;
   assign rsp_caller_stack  = caller_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/prologue_save_slot_scanner_top.sv
// top level of the prologue save-slot scanner
// Takes one 16-bit prologue word per request, one request per cycle while a
// scan runs; a request with start_req set begins a new scan and loads the
// frame base. When a word fails to decode or the fifteenth matched word is
// taken, requests stop until the summary is loaded: a setup step, then a
// walk over the 17 save slots at one slot per cycle, a saved slot waiting
// while the output register is full, through a registered slot-store read
// (one register result per saved slot, ascending), then the summary result
// with last set. Results sit in an output register, so the final request of
// a scan is taken while the previous summary may still wait.
module prologue_save_slot_scanner_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_insn_word,
   input  logic               req_start_req,
   input  logic [31:0]        req_frame_base,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_reg_id,
   output logic [31:0]        rsp_save_address,
   output logic               rsp_is_summary,
   output logic               rsp_leaf,
   output logic               rsp_has_frame_reg,
   output logic signed [31:0] rsp_frame_offset,
   output logic [31:0]        rsp_caller_stack,
   output logic               rsp_last
);
   import psss_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing
   psss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // decode and arithmetic
   psss_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_insn_word     (req_insn_word),
      .req_start_req     (req_start_req),
      .req_frame_base    (req_frame_base),
      .rsp_reg_id        (rsp_reg_id),
      .rsp_save_address  (rsp_save_address),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_leaf          (rsp_leaf),
      .rsp_has_frame_reg (rsp_has_frame_reg),
      .rsp_frame_offset  (rsp_frame_offset),
      .rsp_caller_stack  (rsp_caller_stack),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: rtl/psss_checker.sv
// port-level checker of the prologue save-slot scanner and its bind
`include "prologue_save_slot_scanner_top_macros.svh"

module psss_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [4:0]         rsp_reg_id,
   input logic [31:0]        rsp_save_address,
   input logic               rsp_is_summary,
   input logic               rsp_has_frame_reg,
   input logic signed [31:0] rsp_caller_stack,
   input logic               rsp_last
);
   import psss_pkg::*;

   // a stalled response holds
   `PSSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_reg_id) && $stable(rsp_save_address) && $stable(rsp_last))

   // only the summary closes a run
   `PSSS_ASSERT_NOW(a_last_is_sum, clock, reset, rsp_valid, rsp_is_summary == rsp_last)

   // register results name a real slot
   `PSSS_ASSERT_NOW(a_reg_range, clock, reset, rsp_valid && !rsp_is_summary, rsp_reg_id <= 5'(RET_SLOT))

   // saved frame register leaves the caller stack to the host
   `PSSS_ASSERT_NOW(a_fp_caller, clock, reset, rsp_valid && rsp_is_summary && rsp_has_frame_reg, rsp_caller_stack == 32'sd0)

endmodule

bind prologue_save_slot_scanner_top psss_checker u_psss_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_reg_id        (rsp_reg_id),
   .rsp_save_address  (rsp_save_address),
   .rsp_is_summary    (rsp_is_summary),
   .rsp_has_frame_reg (rsp_has_frame_reg),
   .rsp_caller_stack  (rsp_caller_stack),
   .rsp_last          (rsp_last)
);
